// ===== design/hue_ramp_palette_hsl_to_rgb_defines.svh =====
// Assertion macros for the hue ramp palette block.
`ifndef HUE_RAMP_PALETTE_HSL_TO_RGB_DEFINES_SVH
`define HUE_RAMP_PALETTE_HSL_TO_RGB_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hrp assertion failed");

// Next-cycle implication, checked outside reset.
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hrp assertion failed");

`endif

// ===== design/hrp_pkg.sv =====
// Package with constants, types and helpers of the hue ramp palette block.
`default_nettype none
package hrp_pkg;

  localparam int unsigned IndexBitsDefault = 16;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = 24;
  localparam int unsigned QuotW  = 8;
  localparam int unsigned LevelW = 26;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned KW     = 10;
  localparam int unsigned FW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [IdxW-1:0]  CountReset = 16'd256;
  localparam logic [ChanW-1:0] SatReset   = 8'd150;
  localparam logic [ChanW-1:0] LightReset = 8'd127;

  localparam logic [KW-1:0] KSixth     = 10'd128;
  localparam logic [KW-1:0] KThird     = 10'd256;
  localparam logic [KW-1:0] KHalf      = 10'd384;
  localparam logic [KW-1:0] KTwoThirds = 10'd512;
  localparam logic [KW:0]   KTurn      = 11'd768;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COUNT = 2'd0,
    REG_SAT   = 2'd1,
    REG_LIGHT = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  typedef logic [FW-1:0] factor_t;

  // Ramp weight in 1/128 units for a position on the hue circle.
  function automatic factor_t seg_factor(input logic [KW-1:0] k);
    factor_t f;
    if (k < KSixth) begin
      f = k[FW-1:0];
    end else if (k < KHalf) begin
      f = 8'd128;
    end else if (k < KTwoThirds) begin
      f = FW'(KTwoThirds - k);
    end else begin
      f = '0;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== design/hue_ramp_palette_hsl_to_rgb.sv =====
// Top level of the hue ramp palette block: index to HSL hue to RGB, pipelined.
//
// Usage:
//   Slave stream s_axis_* carries one palette index per item in tdata.
//   Master stream m_axis_* returns one RGB item per index, in order.
//   Configuration (iteration count, saturation, lightness) is written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no item is in flight.
//   Pipeline: one input stage, eight quotient stages of the hue divider,
//   three color stages.
//   Throughput: one item per cycle while the receiver accepts results.
//   Indexes at or above the iteration count give black; zero saturation
//   gives grey at the lightness level.
//   Reset clears all valid bits and loads the register defaults
//   (count 256, saturation 150, lightness 127).
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
`default_nettype none
`include "hue_ramp_palette_hsl_to_rgb_defines.svh"
module hue_ramp_palette_hsl_to_rgb #(
  parameter int unsigned INDEX_BITS = hrp_pkg::IndexBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [hrp_pkg::IdxW-1:0]      s_axis_tdata,  // [15:0] palette_index
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [3*hrp_pkg::ChanW-1:0]        m_axis_tdata,  // blue [23:16], green [15:8], red [7:0]
  input  wire logic                          cfg_we_i,
  input  wire logic [hrp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hrp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hrp_pkg::*;

  localparam int unsigned MaskW = (INDEX_BITS < IdxW) ? INDEX_BITS : IdxW;
  localparam logic [IdxW-1:0] IdxMask = IdxW'((64'd1 << MaskW) - 64'd1);

  logic [IdxW-1:0]  count_q;
  logic [ChanW-1:0] sat_q, light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      sat_q   <= SatReset;
      light_q <= LightReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_COUNT: count_q <= cfg_data_i;
        REG_SAT:   sat_q   <= cfg_data_i[ChanW-1:0];
        REG_LIGHT: light_q <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Levels, static while items are in flight.
  logic [LevelW-1:0] l_lvl, s_lvl, ls_lvl, hi_lvl, lo_lvl, d_lvl;
  logic [2*ChanW-1:0] ls_prod;
  always_comb begin
    ls_prod = light_q * sat_q;
    l_lvl   = {2'b0, light_q, 16'b0};
    s_lvl   = {2'b0, sat_q, 16'b0};
    ls_lvl  = {2'b0, ls_prod, 8'b0};
    hi_lvl  = light_q[ChanW-1] ? (l_lvl + s_lvl - ls_lvl) : (l_lvl + ls_lvl);
    lo_lvl  = {l_lvl[LevelW-2:0], 1'b0} - hi_lvl;
    d_lvl   = hi_lvl - lo_lvl;
  end

  logic [LevelW-1:0] lo_q, d_q;
  always_ff @(posedge clk_i) begin
    lo_q <= lo_lvl;
    d_q  <= d_lvl;
  end

  logic adv;
  assign adv = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = adv;

  // Input stage.
  logic [IdxW-1:0] idx_m;
  logic            v0_q, blk0_q;
  logic [NumW-1:0] num0_q;
  assign idx_m = s_axis_tdata & IdxMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      blk0_q <= (idx_m >= count_q);
      num0_q <= {idx_m, 8'b0} - NumW'(idx_m);
    end
  end

  // Hue divider: one quotient bit per stage.
  logic            dv_q   [QuotW+1];
  logic            dblk_q [QuotW+1];
  logic [NumW-1:0] rem_q [QuotW+1];
  logic [QuotW-1:0] quo_q [QuotW+1];

  assign dv_q[0]   = v0_q;
  assign dblk_q[0] = blk0_q;
  assign rem_q[0]  = num0_q;
  assign quo_q[0]  = '0;

  for (genvar j = 0; j < QuotW; j++) begin : g_div
    logic [NumW-1:0] sub;
    logic            ge;
    assign sub = NumW'(count_q) << (QuotW - 1 - j);
    assign ge  = rem_q[j] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dblk_q[j+1] <= dblk_q[j];
        rem_q[j+1]  <= ge ? (rem_q[j] - sub) : rem_q[j];
        quo_q[j+1]  <= quo_q[j] | (QuotW'(ge) << (QuotW - 1 - j));
      end
    end
  end

  // Stage A: hue positions and ramp weights.
  logic [KW-1:0] kg, kb;
  logic [KW:0]   kr_raw;
  logic [KW-1:0] kr;
  assign kg     = {1'b0, quo_q[QuotW], 1'b0} + KW'(quo_q[QuotW]);
  assign kr_raw = {1'b0, kg} + {1'b0, KThird};
  assign kr     = (kr_raw > KTurn) ? KW'(kr_raw - KTurn) : kr_raw[KW-1:0];
  assign kb     = (kg >= KThird) ? (kg - KThird) : (kg + KTwoThirds);

  logic    va_q, blka_q, graya_q;
  factor_t fr_q, fg_q, fb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= dv_q[QuotW];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      blka_q  <= dblk_q[QuotW];
      graya_q <= (sat_q == '0);
      fr_q    <= seg_factor(kr);
      fg_q    <= seg_factor(kg);
      fb_q    <= seg_factor(kb);
    end
  end

  // Stage B: ramp products.
  logic             vb_q, blkb_q, grayb_q;
  logic [ProdW-1:0] pr_q, pg_q, pb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      blkb_q  <= blka_q;
      grayb_q <= graya_q;
      pr_q    <= ProdW'(d_q) * ProdW'(fr_q);
      pg_q    <= ProdW'(d_q) * ProdW'(fg_q);
      pb_q    <= ProdW'(d_q) * ProdW'(fb_q);
    end
  end

  // Stage C: levels to channels.
  logic [ProdW-1:0] vr, vg, vb;
  logic [ChanW-1:0] r_d, g_d, b_d;
  always_comb begin
    vr = ProdW'(lo_q) + (pr_q >> 7);
    vg = ProdW'(lo_q) + (pg_q >> 7);
    vb = ProdW'(lo_q) + (pb_q >> 7);
    if (blkb_q) begin
      r_d = '0;
      g_d = '0;
      b_d = '0;
    end else if (grayb_q) begin
      r_d = light_q;
      g_d = light_q;
      b_d = light_q;
    end else begin
      r_d = vr[23:16];
      g_d = vg[23:16];
      b_d = vb[23:16];
    end
  end

  logic                 out_v_q;
  logic [3*ChanW-1:0]   out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vb_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {b_d, g_d, r_d};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `HRP_ASSERT_NEXT(a_stall_hold, !adv, $stable(v0_q) && $stable(va_q) && $stable(vb_q))
  `HRP_ASSERT_NEXT(a_black_out, adv && vb_q && blkb_q, m_axis_tdata == '0)
  `HRP_ASSERT_NEXT(a_gray_out, adv && vb_q && grayb_q && !blkb_q,
                   m_axis_tdata[7:0] == m_axis_tdata[15:8] &&
                   m_axis_tdata[15:8] == m_axis_tdata[23:16])

endmodule
`default_nettype wire
